FILE: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants, types and state codes for the page table translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

   localparam int ADDR_BITS    = 16;
   localparam int COUNT_BITS   = 16;
   localparam int PAGE_COUNT   = 256;
   localparam int FRAME_BYTES  = 256;
   localparam int TLB_ENTRIES  = 16;

   localparam int OFFSET_BITS  = $clog2(FRAME_BYTES);
   localparam int PAGE_BITS    = $clog2(PAGE_COUNT);
   localparam int FRAME_BITS   = PAGE_BITS;
   localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);

   typedef logic [PAGE_BITS-1:0]   page_type;
   typedef logic [FRAME_BITS-1:0]  frame_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic      hit;
      frame_type frame;
   } tlb_result_type;

   typedef struct packed {
      logic      en;
      page_type  page;
      frame_type frame;
   } tlb_fill_type;

endpackage

`default_nettype wire

FILE: rtl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical translation: TLB lookup, page map on miss, sequential
// frame allocation on an unmapped page, FIFO refill of the TLB.
//
//  channel   ports                       direction  handshake
//  request   req_logical_address         in         start & !busy
//  response  rsp_* (six fields)          out        rsp_valid, one cycle
//
//  Each word has an accept cycle, which issues the page map read, and a
//  lookup cycle, which uses its registered data and writes back.
//  busy is high in the lookup cycle only; the response shows in the cycle after it,
//  while the next word may already be taken.
//  Reset clears the TLB valid bits, the page map valid bits, counters and
//  the free frame pointer at once; no clearing pass.
//  The receiver cannot stall; nothing is held back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator
   import tlbpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [ADDR_BITS-1:0]  req_logical_address,
   output logic                       rsp_valid,
   output logic [ADDR_BITS-1:0]       rsp_physical_address,
   output logic                       rsp_tlb_hit,
   output logic                       rsp_page_fault,
   output logic                       rsp_out_of_frames,
   output count_type                  rsp_hit_total,
   output count_type                  rsp_fault_total
);

   state_type              state_ff, state_in;
   page_type               page_ff, page_in;
   offset_type             offset_ff, offset_in;
   logic [PAGE_COUNT-1:0]  map_valid_ff, map_valid_in;
   logic [PAGE_BITS:0]     next_free_ff, next_free_in;
   count_type              hit_cnt_ff, hit_cnt_in;
   count_type              fault_cnt_ff, fault_cnt_in;
   frame_type              map_rd_ff;
   frame_type              map_frame_mem [PAGE_COUNT];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]   rsp_phys_ff, rsp_phys_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic                   rsp_oof_ff, rsp_oof_in;

   page_type               req_page;
   logic                   accept;
   logic                   map_wr_en;
   logic                   mapped;
   logic                   exhausted;
   frame_type              frame;
   tlb_fill_type           fill;
   tlb_result_type         tlb_res;

   assign req_page = req_logical_address[OFFSET_BITS +: PAGE_BITS];
   assign busy     = (state_ff == ST_LOOKUP);
   assign accept   = start && !busy;

   tlbpt_tlb u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (page_ff),
      .fill        (fill),
      .result      (tlb_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_valid_ff <= '0;
         next_free_ff <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_valid_ff <= map_valid_in;
         next_free_ff <= next_free_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      offset_ff   <= offset_in;
      rsp_phys_ff <= rsp_phys_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_oof_ff  <= rsp_oof_in;
   end

   // page map: one read port, one write port
   always_ff @(posedge clock) begin
      if (accept) begin
         map_rd_ff <= map_frame_mem[req_page];
      end
      if (map_wr_en) begin
         map_frame_mem[page_ff] <= next_free_ff[FRAME_BITS-1:0];
      end
   end

   always_comb begin
      mapped    = map_valid_ff[page_ff];
      exhausted = !tlb_res.hit && !mapped && next_free_ff[PAGE_BITS];
      if (tlb_res.hit) begin
         frame = tlb_res.frame;
      end else if (mapped) begin
         frame = map_rd_ff;
      end else begin
         frame = next_free_ff[FRAME_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      map_valid_in = map_valid_ff;
      next_free_in = next_free_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_phys_in  = rsp_phys_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_oof_in   = rsp_oof_ff;
      map_wr_en    = 1'b0;
      fill         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               page_in   = req_page;
               offset_in = req_logical_address[OFFSET_BITS-1:0];
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = tlb_res.hit;
            rsp_oof_in   = exhausted;
            rsp_fault_in = !tlb_res.hit && !mapped && !exhausted;
            rsp_phys_in  = exhausted ? '0 : ADDR_BITS'({frame, offset_ff});
            if (tlb_res.hit) begin
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end
            end else if (!exhausted) begin
               fill.en    = 1'b1;
               fill.page  = page_ff;
               fill.frame = frame;
               if (!mapped) begin
                  map_wr_en             = 1'b1;
                  map_valid_in[page_ff] = 1'b1;
                  next_free_in          = next_free_ff + 1'b1;
                  if (fault_cnt_ff != '1) begin
                     fault_cnt_in = fault_cnt_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_out_of_frames    = rsp_oof_ff;
   assign rsp_hit_total        = hit_cnt_ff;
   assign rsp_fault_total      = fault_cnt_ff;

`ifndef SYNTH
   a_lookup_responds: assert property (@(posedge clock) disable iff (reset)
      busy && !reset |=> rsp_valid)
      else $error("lookup cycle without response");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_tlb_hit, rsp_page_fault, rsp_out_of_frames}))
      else $error("more than one outcome flag");

   a_frames_match_map: assert property (@(posedge clock) disable iff (reset)
      $countones(map_valid_ff) == int'(next_free_ff))
      else $error("allocated frames differ from mapped pages");

   a_free_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> next_free_ff >= $past(next_free_ff))
      else $error("free frame pointer moved back");

   a_no_alloc_on_hit: assert property (@(posedge clock) disable iff (reset)
      busy && tlb_res.hit |=> $stable(next_free_ff) && $stable(map_valid_ff))
      else $error("page map changed on a TLB hit");
`endif

endmodule

`default_nettype wire

FILE: rtl/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB, lowest matching entry wins, FIFO replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_tlb
   import tlbpt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire page_type       lookup_page,
   input  wire tlb_fill_type   fill,
   output tlb_result_type      result
);

   page_type                 tag_ff   [TLB_ENTRIES];
   frame_type                frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]   valid_ff;
   logic [TLB_IDX_BITS-1:0]  ptr_ff;
   logic [TLB_IDX_BITS-1:0]  ptr_in;

   assign ptr_in = ptr_ff + 1'b1;

   always_comb begin
      result.hit   = 1'b0;
      result.frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == lookup_page)) begin
            result.hit   = 1'b1;
            result.frame = frame_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (fill.en) begin
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill.en) begin
         tag_ff[ptr_ff]   <= fill.page;
         frame_ff[ptr_ff] <= fill.frame;
      end
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tlb_page_table_translator. Logical addresses are
// sent through the start/busy handshake with random gaps. A local translator
// model keeps its own TLB, page map, frame allocator and counters, and each
// response word is checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
   import tlbpt_pkg::*;
();

   typedef struct packed {
      logic [ADDR_BITS-1:0] phys;
      logic                 hit;
      logic                 fault;
      logic                 no_frame;
      count_type            hits;
      count_type            faults;
   } xlat_word_type;

   localparam int QUIET_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [ADDR_BITS-1:0] req_logical_address = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [ADDR_BITS-1:0] rsp_physical_address;
   logic                 rsp_tlb_hit;
   logic                 rsp_page_fault;
   logic                 rsp_out_of_frames;
   count_type            rsp_hit_total;
   count_type            rsp_fault_total;

   tlb_page_table_translator uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_out_of_frames    (rsp_out_of_frames),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // translator model state
   page_type                model_tag   [TLB_ENTRIES];
   frame_type               model_frm   [TLB_ENTRIES];
   logic                    model_ok    [TLB_ENTRIES];
   logic                    map_ok      [PAGE_COUNT];
   frame_type               map_frm     [PAGE_COUNT];
   logic [TLB_IDX_BITS-1:0] fifo_slot;
   logic [PAGE_BITS:0]      free_frame;
   count_type               hit_cnt;
   count_type               fault_cnt;

   xlat_word_type expected_xlat[$];
   int         error_count = 0;
   int         quiet_cycles = 0;
   logic       burst = 1'b0;
   page_type   hot_pages[24];
   int         hot_count = 8;

   function automatic xlat_word_type translate_address(input logic [ADDR_BITS-1:0] addr);
      xlat_word_type r;
      page_type   pg;
      offset_type off;
      frame_type  fr;
      logic       found;
      logic       have;
      logic [31:0] full;
      pg    = page_type'(addr >> OFFSET_BITS);
      off   = offset_type'(addr);
      fr    = '0;
      found = 1'b0;
      have  = 1'b1;
      r     = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!found && model_ok[i] && model_tag[i] == pg) begin
            found = 1'b1;
            fr    = model_frm[i];
         end
      end
      if (found) begin
         if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
      end else begin
         if (map_ok[pg]) begin
            fr = map_frm[pg];
         end else if (free_frame >= PAGE_COUNT) begin
            r.no_frame = 1'b1;
            have       = 1'b0;
         end else begin
            fr          = frame_type'(free_frame);
            free_frame  = free_frame + 1'b1;
            map_ok[pg]  = 1'b1;
            map_frm[pg] = fr;
            r.fault     = 1'b1;
            if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
         end
         if (have) begin
            model_tag[fifo_slot] = pg;
            model_frm[fifo_slot] = fr;
            model_ok[fifo_slot]  = 1'b1;
            fifo_slot = (fifo_slot == TLB_ENTRIES - 1) ? '0 : fifo_slot + 1'b1;
         end
      end
      if (!r.no_frame) begin
         full   = (32'(fr) << OFFSET_BITS) | 32'(off);
         r.phys = full[ADDR_BITS-1:0];
      end
      r.hit    = found;
      r.hits   = hit_cnt;
      r.faults = fault_cnt;
      return r;
   endfunction

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   // start stays high between back-to-back words; it is lowered only for a gap
   task automatic send_word(input logic [ADDR_BITS-1:0] addr, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_logical_address <= addr;
      do @(posedge clock); while (busy);
      expected_xlat.push_back(translate_address(addr));
   endtask

   function automatic logic [ADDR_BITS-1:0] make_addr(input page_type pg);
      offset_type off;
      case ($urandom_range(0, 7))
         0: off = '0;
         1: off = '1;
         default: off = offset_type'($urandom);
      endcase
      return ADDR_BITS'((32'(pg) << OFFSET_BITS) | 32'(off));
   endfunction

   // address extremes, immediate reuse, FIFO wrap and eviction
   task automatic test_directed();
      send_word(16'h0000, 0);
      send_word(16'h00FF, 0);
      send_word(16'hFFFF, 3);
      send_word(16'hFF00, 0);
      send_word(16'h8000, 5);
      send_word(16'h7FFF, 0);
      send_word(16'h80AA, 1);
      send_word(16'h7F55, 0);
      for (int p = 16; p <= 32; p++) send_word(make_addr(page_type'(p)), p % 3);
      // page 0 has been evicted: miss, page map read, no fault
      send_word(16'h0012, 0);
      send_word(16'h00ED, 0);
   endtask

   task automatic test_working_set();
      page_type pg;
      for (int seg = 0; seg < 14; seg++) begin
         burst     = ($urandom_range(0, 2) == 0);
         hot_count = $urandom_range(2, 24);
         for (int k = 0; k < hot_count; k++) hot_pages[k] = page_type'($urandom);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 75) pg = hot_pages[$urandom_range(0, hot_count - 1)];
            else pg = page_type'($urandom);
            if ($urandom_range(0, 9) == 0) send_word(ADDR_BITS'($urandom), draw_gap());
            else send_word(make_addr(pg), draw_gap());
         end
      end
      burst = 1'b0;
   endtask

   // touches every page, so the frame allocator runs up to its last frame
   task automatic test_map_all_pages();
      page_type order[PAGE_COUNT];
      page_type tmp;
      int       j;
      for (int p = 0; p < PAGE_COUNT; p++) order[p] = page_type'(p);
      for (int p = PAGE_COUNT - 1; p > 0; p--) begin
         j        = $urandom_range(0, p);
         tmp      = order[p];
         order[p] = order[j];
         order[j] = tmp;
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
         if (p % 64 == 0) burst = ($urandom_range(0, 1) == 0);
         send_word(make_addr(order[p]), draw_gap());
      end
      burst = 1'b0;
   endtask

   task automatic test_mapped_random();
      for (int n = 0; n < 150; n++) begin
         if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
         send_word(ADDR_BITS'($urandom), draw_gap());
      end
      burst = 1'b0;
   endtask

   always @(posedge clock) begin
      xlat_word_type got;
      xlat_word_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_physical_address, rsp_tlb_hit, rsp_page_fault, rsp_out_of_frames,
                rsp_hit_total, rsp_fault_total};
         if (expected_xlat.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: unexpected response word pa=%h hit=%b", got.phys, got.hit);
         end else begin
            want = expected_xlat.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: pa exp %h got %h, hit exp %b got %b, fault exp %b got %b",
                           want.phys, got.phys, want.hit, got.hit, want.fault, got.fault);
                  $display("       oof exp %b got %b, hits exp %0d got %0d, faults exp %0d got %0d",
                           want.no_frame, got.no_frame, want.hits, got.hits,
                           want.faults, got.faults);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (model_ok[i]) begin
         model_ok[i]  = 1'b0;
         model_tag[i] = '0;
         model_frm[i] = '0;
      end
      foreach (map_ok[i]) begin
         map_ok[i]  = 1'b0;
         map_frm[i] = '0;
      end
      fifo_slot  = '0;
      free_frame = '0;
      hit_cnt    = '0;
      fault_cnt  = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_working_set();
      test_map_all_pages();
      test_mapped_random();
      start <= 1'b0;

      while (expected_xlat.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_xlat.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
